// ----- rtl/lshc_pkg.sv -----
// Shared constants for the letter-set hash counter.
package lshc_pkg;

    // Field widths and limits.
    localparam int SET_BITS    = 26;
    localparam int TOTAL_BITS  = 20;
    localparam int MAX_LETTERS = 7;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // Table geometry defaults.
    localparam int TABLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 20;

    // Hash finalizer multipliers.
    localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

    // Item modes.
    localparam logic [1:0] MODE_WORD   = 2'd0;
    localparam logic [1:0] MODE_PUZZLE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_COUNTED = 3'd0;
    localparam logic [2:0] KIND_SKIPPED = 3'd1;
    localparam logic [2:0] KIND_DROPPED = 3'd2;
    localparam logic [2:0] KIND_PUZZLE  = 3'd3;
    localparam logic [2:0] KIND_CLEARED = 3'd4;

endpackage

// ----- rtl/lshc_letter_if.sv -----
// Input channel carrying one letter item.
interface lshc_letter_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [4:0] letter;
    logic       last;

    modport source (output valid, output mode, output letter, output last, input ready);
    modport sink   (input valid, input mode, input letter, input last, output ready);
endinterface

// ----- rtl/lshc_result_if.sv -----
// Output channel carrying one result item.
interface lshc_result_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       kind;
    logic [lshc_pkg::TOTAL_BITS-1:0]  total;

    modport source (output valid, output kind, output total, input ready);
    modport sink   (input valid, input kind, input total, output ready);
endinterface

// ----- rtl/letter_set_hash_count_subset_query.sv -----
// Top level: letter-set word counter with puzzle subset query.
//
// Word letters are accepted one per cycle while the block is idle and holds no pending
// result. A finished word goes through the hash states ST_HASH1 to ST_HASH3 and then a
// read and a check per probe of the linear-probing table, whose memory has a registered
// read. A puzzle end walks up to 64 subsets, each taking a subset-select step, the hash
// states and a read and a check per probe. A clear item, and reset itself, sweep all
// 2^TABLE_BITS table entries (4096 by default) one entry per cycle, during which no
// item is taken. A result waits in an output register while the next item is accepted.
module letter_set_hash_count_subset_query #(
    parameter int TABLE_BITS = lshc_pkg::TABLE_BITS_DEF,
    parameter int COUNT_BITS = lshc_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lshc_letter_if.sink          letters,
    lshc_result_if.source        results
);

    localparam int SB = lshc_pkg::SET_BITS;
    localparam int TB = lshc_pkg::TOTAL_BITS;
    localparam int MW = SB + COUNT_BITS;
    localparam int SW = ((COUNT_BITS > TB) ? COUNT_BITS : TB) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_HASH1 = 3'd2;
    localparam logic [2:0] ST_HASH2 = 3'd3;
    localparam logic [2:0] ST_HASH3 = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_CHECK = 3'd6;
    localparam logic [2:0] ST_QNEXT = 3'd7;

    // Sets with at most seven letters are counted.
    function automatic logic [4:0] pop_count(input logic [SB-1:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < SB; i++)
        begin
            n = n + 5'(v[i]);
        end
        return n;
    endfunction

    logic [2:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic [2:0]            res_kind_reg, res_kind_next;
    logic [SB-1:0]         word_set_reg, word_set_next;
    logic [SB-1:0]         req_reg, req_next;
    logic [SB-1:0]         opt_reg, opt_next;
    logic [2:0]            ppos_reg, ppos_next;
    logic [SB-1:0]         q_req_reg, q_req_next;
    logic [SB-1:0]         q_opt_reg, q_opt_next;
    logic [SB-1:0]         sub_reg, sub_next;
    logic [TB-1:0]         sum_reg, sum_next;
    logic                  is_query_reg, is_query_next;
    logic                  clr_report_reg, clr_report_next;
    logic [TABLE_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [SB-1:0]         key_reg, key_next;
    logic [31:0]           h_reg, h_next;
    logic [TABLE_BITS-1:0] pos_reg, pos_next;
    logic [TABLE_BITS-1:0] n_reg, n_next;
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            out_kind_reg, out_kind_next;
    logic [TB-1:0]         out_total_reg, out_total_next;

    // Table memory: key in the upper bits, count in the lower bits.
    logic [MW-1:0]         mem [0:(1 << TABLE_BITS)-1];
    logic [MW-1:0]         mem_rdata_reg;
    logic                  mem_re;
    logic                  mem_we;
    logic [TABLE_BITS-1:0] mem_waddr;
    logic [MW-1:0]         mem_wdata;

    logic                  accept;
    logic [SB-1:0]         bit_in;
    logic [SB-1:0]         set_new;
    logic [SB-1:0]         q_key;
    logic [31:0]           k32;
    logic [31:0]           mix_a;
    logic [31:0]           mix_b;
    logic [31:0]           mix_c;
    logic [SB-1:0]         rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [SW-1:0]         sum_ext;
    logic                  out_load;

    assign accept  = letters.valid && letters.ready;
    assign bit_in  = (letters.letter < 5'd26) ? (SB'(1) << letters.letter) : '0;
    assign set_new = word_set_reg | bit_in;
    assign q_key   = sub_reg | q_req_reg;

    // Murmur finalizer, one multiply per cycle.
    assign k32   = 32'(key_reg);
    assign mix_a = k32 ^ (k32 >> 16);
    assign mix_b = h_reg ^ (h_reg >> 13);
    assign mix_c = h_reg ^ (h_reg >> 16);

    assign rd_key  = mem_rdata_reg[COUNT_BITS +: SB];
    assign rd_cnt  = mem_rdata_reg[COUNT_BITS-1:0];
    assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
    assign sum_ext = SW'(sum_reg) + SW'(rd_cnt);

    assign letters.ready = (state_reg == ST_IDLE) && !done_reg;
    assign out_load      = done_reg && (!out_valid_reg || results.ready);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        done_next       = done_reg;
        res_kind_next   = res_kind_reg;
        word_set_next   = word_set_reg;
        req_next        = req_reg;
        opt_next        = opt_reg;
        ppos_next       = ppos_reg;
        q_req_next      = q_req_reg;
        q_opt_next      = q_opt_reg;
        sub_next        = sub_reg;
        sum_next        = sum_reg;
        is_query_next   = is_query_reg;
        clr_report_next = clr_report_reg;
        clr_addr_next   = clr_addr_reg;
        key_next        = key_reg;
        h_next          = h_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = '0;

        if (out_load)
        begin
            done_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (letters.mode)
                        lshc_pkg::MODE_WORD:
                        begin
                            word_set_next = set_new;
                            if (letters.last)
                            begin
                                word_set_next = '0;
                                is_query_next = 1'b0;
                                if (set_new == '0 ||
                                    pop_count(set_new) > 5'(lshc_pkg::MAX_LETTERS))
                                begin
                                    res_kind_next = lshc_pkg::KIND_SKIPPED;
                                    done_next     = 1'b1;
                                end
                                else
                                begin
                                    key_next   = set_new;
                                    state_next = ST_HASH1;
                                end
                            end
                        end
                        lshc_pkg::MODE_PUZZLE:
                        begin
                            if (ppos_reg == 3'd0)
                            begin
                                req_next = bit_in;
                            end
                            else if (ppos_reg < 3'(lshc_pkg::MAX_LETTERS))
                            begin
                                opt_next = opt_reg | bit_in;
                            end
                            if (ppos_reg < 3'(lshc_pkg::MAX_LETTERS))
                            begin
                                ppos_next = ppos_reg + 3'd1;
                            end
                            if (letters.last)
                            begin
                                q_req_next    = req_next;
                                q_opt_next    = opt_next;
                                sub_next      = opt_next;
                                sum_next      = '0;
                                is_query_next = 1'b1;
                                req_next      = '0;
                                opt_next      = '0;
                                ppos_next     = '0;
                                state_next    = ST_QNEXT;
                            end
                        end
                        lshc_pkg::MODE_CLEAR:
                        begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + TABLE_BITS'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                    if (clr_report_reg)
                    begin
                        res_kind_next = lshc_pkg::KIND_CLEARED;
                        done_next     = 1'b1;
                    end
                end
            end
            ST_HASH1:
            begin
                h_next     = mix_a * lshc_pkg::MIX_C1;
                state_next = ST_HASH2;
            end
            ST_HASH2:
            begin
                h_next     = mix_b * lshc_pkg::MIX_C2;
                state_next = ST_HASH3;
            end
            ST_HASH3:
            begin
                pos_next   = mix_c[TABLE_BITS-1:0];
                n_next     = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!is_query_reg)
                begin
                    if (rd_key == '0 || rd_key == key_reg)
                    begin
                        mem_we        = 1'b1;
                        mem_wdata     = {key_reg, cnt_inc};
                        res_kind_next = lshc_pkg::KIND_COUNTED;
                        done_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (n_reg == '1)
                    begin
                        res_kind_next = lshc_pkg::KIND_DROPPED;
                        done_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + TABLE_BITS'(1);
                        n_next     = n_reg + TABLE_BITS'(1);
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    if (rd_key == '0 || n_reg == '1)
                    begin
                        if (rd_key == key_reg)
                        begin
                            sum_next = (sum_ext > SW'(lshc_pkg::TOTAL_MAX)) ?
                                       lshc_pkg::TOTAL_MAX : sum_ext[TB-1:0];
                        end
                        state_next = ST_QNEXT;
                    end
                    else if (rd_key == key_reg)
                    begin
                        sum_next   = (sum_ext > SW'(lshc_pkg::TOTAL_MAX)) ?
                                     lshc_pkg::TOTAL_MAX : sum_ext[TB-1:0];
                        state_next = ST_QNEXT;
                    end
                    else
                    begin
                        pos_next   = pos_reg + TABLE_BITS'(1);
                        n_next     = n_reg + TABLE_BITS'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_QNEXT:
            begin
                // Look up the current subset, or finish once the empty one is done.
                if (q_key == '0)
                begin
                    res_kind_next = lshc_pkg::KIND_PUZZLE;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    key_next   = q_key;
                    state_next = ST_HASH1;
                end
                // After the empty subset the key goes to zero, which ends the walk.
                if (sub_reg == '0)
                begin
                    q_req_next = '0;
                    sub_next   = '0;
                end
                else
                begin
                    sub_next = (sub_reg - SB'(1)) & q_opt_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_total_next = out_total_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = res_kind_reg;
            out_total_next = (res_kind_reg == lshc_pkg::KIND_PUZZLE) ? sum_reg : '0;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.kind  = out_kind_reg;
    assign results.total = out_total_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            done_reg       <= 1'b0;
            word_set_reg   <= '0;
            req_reg        <= '0;
            opt_reg        <= '0;
            ppos_reg       <= '0;
            is_query_reg   <= 1'b0;
            clr_report_reg <= 1'b0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            word_set_reg   <= word_set_next;
            req_reg        <= req_next;
            opt_reg        <= opt_next;
            ppos_reg       <= ppos_next;
            is_query_reg   <= is_query_next;
            clr_report_reg <= clr_report_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_kind_reg  <= res_kind_next;
        q_req_reg     <= q_req_next;
        q_opt_reg     <= q_opt_next;
        sub_reg       <= sub_next;
        sum_reg       <= sum_next;
        key_reg       <= key_next;
        h_reg         <= h_next;
        pos_reg       <= pos_next;
        n_reg         <= n_next;
        out_kind_reg  <= out_kind_next;
        out_total_reg <= out_total_next;
    end

    // Table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[pos_reg];
        end
    end

    // A probe check always follows its memory read.
    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> $past(state_reg) == ST_READ)
        else $error("probe check without a preceding read");

    // Puzzle lookups never write the table.
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && is_query_reg) |-> !mem_we)
        else $error("table written during a puzzle lookup");

    // Only puzzle results carry a total.
    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != lshc_pkg::KIND_PUZZLE) |-> out_total_reg == '0)
        else $error("nonzero total on a non-puzzle result");

    // The puzzle position stops at seven.
    a_ppos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ppos_reg <= 3'(lshc_pkg::MAX_LETTERS))
        else $error("puzzle position beyond seven");

endmodule
